// File: rtl/core/chr_pkg.sv
// Package for the consistent hash ring: mode and status codes, shared types.
// No dependencies.
`default_nettype none
package chr_pkg;
  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  // no operation, reported as ok
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_DUP   = 3'd3;
  localparam logic [2:0] ST_MISS  = 3'd4;

  // number of meaningful node ids; node_id is stored as given
  localparam int MAX_NODES = 16;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_SRCH_RD, S_SHIFT, S_SHIFT_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key_hash;
    logic [3:0]  node_id;
  } in_item_t;

  typedef struct packed {
    logic [3:0] owner_node;
    logic [2:0] status;
    logic [8:0] entry_count;
  } out_item_t;
endpackage
`default_nettype wire

// File: rtl/core/chr_if.sv
// Valid/ready channel interfaces for the ring's input and result streams.
// Depends on chr_pkg.
`default_nettype none
interface chr_in_if;
  logic           valid;
  logic           ready;
  chr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface chr_out_if;
  logic            valid;
  logic            ready;
  chr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/consistent_hash_ring.sv
// Consistent hash ring: sorted positions with owners, lookup/insert/delete.
// Usage:
//   in_*  : one transaction per item (mode, key_hash, node_id).
//   out_* : one transaction per item (owner_node, status, entry_count).
// An item is taken only when the block is idle. A binary search over the
// memory follows, one probe at a time (registered read), at most
// log2(RING_SIZE)+1 probes. Insert then moves the entries at and above
// the found index up one place, and delete moves the entries above it
// down one place, one entry at a time through the single memory. The
// block returns to idle, ready for the next item, once a result is loaded.
// Reset empties the ring at once (count to zero); memory contents are not
// cleared, since only entries below the count are read.
// The result sits in an output register until taken; while the receiver
// stalls the block takes and processes one more item, then holds it.
// RING_SIZE must be a power of two.
`default_nettype none
module consistent_hash_ring #(
  parameter int RING_SIZE = 256
) (
  input wire logic clk,
  input wire logic rst_n,
  chr_in_if.sink   in_ch,
  chr_out_if.source out_ch
);
  localparam int AW = $clog2(RING_SIZE);
  localparam int CW = AW + 1;

  chr_pkg::state_t state_r, state_nxt;
  chr_pkg::in_item_t item_r;
  logic [CW-1:0] cnt_r, lo_r, hi_r, idx_r;
  logic [CW-1:0] cnt_nxt, lo_nxt, hi_nxt, idx_nxt;
  logic [35:0]   hold_r, hold_nxt;
  logic [35:0]   hit_r, hit_nxt;
  chr_pkg::out_item_t res_r, res_nxt;
  chr_pkg::out_item_t out_r, out_nxt;
  logic          ovalid_r, ovalid_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [35:0]   wdata, rdata;
  logic [CW-1:0] mid;
  logic [CW-1:0] lb;
  logic          found;
  logic [CW-1:0] shift_end;
  logic          shift_done;

  chr_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign in_ch.ready = (state_r == chr_pkg::S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = out_r;
  assign found = (lo_r < cnt_r) && (hit_r[35:4] == item_r.key_hash);
  assign lb = lo_r;

  // insert writes through the old top entry, delete stops below the count
  assign shift_end = (item_r.mode == chr_pkg::MODE_INSERT && res_r.status == chr_pkg::ST_OK)
                     ? cnt_r + CW'(1) : cnt_r;
  assign shift_done = (idx_r == shift_end);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      chr_pkg::S_IDLE:     if (in_ch.valid) state_nxt = chr_pkg::S_SRCH;
      chr_pkg::S_SRCH:     if (lo_r < hi_r) state_nxt = chr_pkg::S_SRCH_RD;
                           else state_nxt = chr_pkg::S_SHIFT;
      chr_pkg::S_SRCH_RD:  state_nxt = chr_pkg::S_SRCH;
      chr_pkg::S_SHIFT:    if (shift_done) state_nxt = chr_pkg::S_DONE;
                           else state_nxt = chr_pkg::S_SHIFT_WR;
      chr_pkg::S_SHIFT_WR: state_nxt = chr_pkg::S_SHIFT;
      chr_pkg::S_DONE:     if (!ovalid_r || out_ch.ready) state_nxt = chr_pkg::S_IDLE;
      default:             state_nxt = chr_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt = cnt_r; lo_nxt = lo_r; hi_nxt = hi_r; idx_nxt = idx_r;
    hold_nxt = hold_r; hit_nxt = hit_r; res_nxt = res_r;
    out_nxt = out_r;
    ovalid_nxt = ovalid_r;
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = mid[AW-1:0];
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    case (state_r)
      chr_pkg::S_IDLE: begin
        lo_nxt = '0; hi_nxt = cnt_r;
        raddr = '0;
      end
      chr_pkg::S_SRCH: begin
        if (lo_r >= hi_r) begin
          // search ends: lo is the lower bound; decide the operation
          res_nxt = '0;
          res_nxt.entry_count = 9'(cnt_r);
          idx_nxt = cnt_r;
          raddr = lb[AW-1:0];
        end
      end
      chr_pkg::S_SRCH_RD: begin
        if (rdata[35:4] < item_r.key_hash) lo_nxt = mid + 1'b1;
        else begin
          hi_nxt = mid;
          hit_nxt = rdata;
        end
      end
      default: ;
    endcase
    // operation decision on the search end
    if (state_r == chr_pkg::S_SRCH && lo_r >= hi_r) begin
      case (item_r.mode)
        chr_pkg::MODE_LOOKUP: begin
          if (cnt_r == '0) res_nxt.status = chr_pkg::ST_EMPTY;
          else raddr = (lb >= cnt_r) ? '0 : lb[AW-1:0];
        end
        chr_pkg::MODE_INSERT: begin
          if (found) res_nxt.status = chr_pkg::ST_DUP;
          else if (cnt_r >= CW'(RING_SIZE)) res_nxt.status = chr_pkg::ST_FULL;
          else begin
            idx_nxt = lb;
            hold_nxt = {item_r.key_hash, item_r.node_id};
            res_nxt.entry_count = 9'(cnt_r + 1'b1);
          end
        end
        chr_pkg::MODE_DELETE: begin
          if (cnt_r == '0) res_nxt.status = chr_pkg::ST_EMPTY;
          else if (!found) res_nxt.status = chr_pkg::ST_MISS;
          else begin
            idx_nxt = lb;
            res_nxt.entry_count = 9'(cnt_r - 1'b1);
            raddr = AW'(lb + 1'b1);
          end
        end
        default: ;
      endcase
    end
    // shift: insert writes hold at idx and carries the old entry upward;
    // delete copies idx+1 down to idx
    if (state_r == chr_pkg::S_SHIFT) begin
      raddr = (item_r.mode == chr_pkg::MODE_INSERT) ? idx_r[AW-1:0]
                                                    : AW'(idx_r + 2'd2);
      if (shift_done && res_r.status == chr_pkg::ST_OK) begin
        if (item_r.mode == chr_pkg::MODE_INSERT) cnt_nxt = cnt_r + CW'(1);
        else if (item_r.mode == chr_pkg::MODE_DELETE) cnt_nxt = cnt_r - CW'(1);
      end
    end
    if (state_r == chr_pkg::S_SHIFT_WR) begin
      we = 1'b1;
      waddr = idx_r[AW-1:0];
      idx_nxt = idx_r + 1'b1;
      if (item_r.mode == chr_pkg::MODE_INSERT) begin
        wdata = hold_r;
        hold_nxt = rdata;
        raddr = AW'(idx_r + 1'b1);
      end else begin
        wdata = hold_r;
        hold_nxt = rdata;
        raddr = AW'(idx_r + 2'd3);
      end
    end
    // lookup owner capture in the cycle after the search ended
    if (state_r == chr_pkg::S_SHIFT && item_r.mode == chr_pkg::MODE_LOOKUP
        && res_r.status == chr_pkg::ST_OK) begin
      res_nxt.owner_node = rdata[3:0];
    end
    if (state_r == chr_pkg::S_SHIFT && idx_r != cnt_r
        && item_r.mode == chr_pkg::MODE_DELETE && idx_r == lb) begin
      hold_nxt = rdata;
    end
    // load the output register once it is free
    if (state_r == chr_pkg::S_DONE && (!ovalid_r || out_ch.ready)) begin
      ovalid_nxt = 1'b1;
      out_nxt = res_r;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= chr_pkg::S_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == chr_pkg::S_IDLE && in_ch.valid) item_r <= in_ch.data;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    idx_r  <= idx_nxt;
    hold_r <= hold_nxt;
    hit_r  <= hit_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end
endmodule
`default_nettype wire

// File: rtl/core/chr_mem.sv
// Ring storage: one synchronous RAM of position and owner, registered read.
// Depends on nothing but its parameters.
`default_nettype none
module chr_mem #(
  parameter int AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [35:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [35:0]   rdata
);
  logic [35:0] mem [2**AW];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: dv/chr_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side note: the channel interfaces come from rtl/core/chr_if.sv.
// This file holds shared testbench constants; it has no dependencies.
package chr_tb_pkg;
  localparam int RING_DEPTH = 256;
  localparam int IDLE_PCT   = 9;
endpackage

// File: dv/chr_checker.sv
`timescale 1ns / 100ps
// Checker for the consistent hash ring: mirrors the sorted ring, predicts one
// result per accepted item and compares it. Needs chr_pkg, chr_tb_pkg, chr_if.
module chr_checker (
  input  logic      clk,
  input  logic      rst_n,
  chr_in_if         in_ch,
  chr_out_if        out_ch,
  output int        fail_count,
  output int        pending,
  output int        lookups_seen,
  output int        full_seen
);
  logic [31:0] ring_pos[$];
  logic [3:0]  ring_own[$];
  chr_pkg::out_item_t expected_q[$];

  // First index whose position is >= h
  function automatic int first_at_or_above(logic [31:0] h);
    int i;
    for (i = 0; i < ring_pos.size(); i++)
      if (ring_pos[i] >= h) return i;
    return ring_pos.size();
  endfunction

  function automatic chr_pkg::out_item_t apply_item(chr_pkg::in_item_t it);
    chr_pkg::out_item_t r;
    int idx;
    r = '0;
    idx = first_at_or_above(it.key_hash);
    case (it.mode)
      chr_pkg::MODE_LOOKUP: begin
        lookups_seen++;
        if (ring_pos.size() == 0) r.status = chr_pkg::ST_EMPTY;
        else r.owner_node = ring_own[(idx >= ring_pos.size()) ? 0 : idx];
      end
      chr_pkg::MODE_INSERT: begin
        if (idx < ring_pos.size() && ring_pos[idx] == it.key_hash)
          r.status = chr_pkg::ST_DUP;
        else if (ring_pos.size() >= chr_tb_pkg::RING_DEPTH) begin
          r.status = chr_pkg::ST_FULL;
          full_seen++;
        end else begin
          ring_pos.insert(idx, it.key_hash);
          ring_own.insert(idx, it.node_id);
        end
      end
      chr_pkg::MODE_DELETE: begin
        if (ring_pos.size() == 0) r.status = chr_pkg::ST_EMPTY;
        else if (idx < ring_pos.size() && ring_pos[idx] == it.key_hash) begin
          ring_pos.delete(idx);
          ring_own.delete(idx);
        end else r.status = chr_pkg::ST_MISS;
      end
      default: ;
    endcase
    r.entry_count = 9'(ring_pos.size());
    return r;
  endfunction

  // Predict on input transactions, compare on result transactions
  always @(posedge clk) begin
    chr_pkg::out_item_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      lookups_seen = 0;
      full_seen = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) expected_q.push_back(apply_item(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_ch.data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== out_ch.data) begin
            $display("%0t: mismatch expected owner=%0d status=%0d count=%0d",
                     $realtime, exp_r.owner_node, exp_r.status, exp_r.entry_count);
            $display("%0t:          actual owner=%0d status=%0d count=%0d",
                     $realtime, out_ch.data.owner_node, out_ch.data.status,
                     out_ch.data.entry_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the ring testbench: clock, reset, stimulus and verdict.
// Uses chr_pkg, chr_tb_pkg, chr_if, chr_checker and consistent_hash_ring.
module testbench;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  int   fail_count, pending, lookups_seen, full_seen;
  int   idle_cycles;
  bit   no_idle;
  logic [31:0] used_pos[$];

  chr_in_if  in_ch();
  chr_out_if out_ch();

  consistent_hash_ring i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  chr_checker i_checker (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                         .fail_count(fail_count), .pending(pending),
                         .lookups_seen(lookups_seen), .full_seen(full_seen));

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random except during the quiet stretch
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= chr_tb_pkg::IDLE_PCT);
  end

  // Watchdog: count cycles with no transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Send one transaction, with an optional random gap before it;
  // valid stays up after acceptance until the next call decides
  task automatic send_item(logic [1:0] m, logic [31:0] h, logic [3:0] n);
    while (!no_idle && $urandom_range(99) < chr_tb_pkg::IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{mode: m, key_hash: h, node_id: n};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [31:0] pick_pos();
    if (used_pos.size() > 0 && $urandom_range(2) == 0)
      return used_pos[$urandom_range(used_pos.size() - 1)];
    return ($urandom_range(3) == 0) ? 32'($urandom_range(63)) << 26 : $urandom;
  endfunction

  task automatic random_item();
    int r;
    logic [31:0] h;
    r = $urandom_range(99);
    h = pick_pos();
    if (r < 45) begin
      used_pos.push_back(h);
      send_item(chr_pkg::MODE_INSERT, h, 4'($urandom));
    end else if (r < 70)
      send_item(chr_pkg::MODE_LOOKUP, $urandom_range(3) == 0 ? h : $urandom,
                4'($urandom));
    else if (r < 97) send_item(chr_pkg::MODE_DELETE, h, 4'($urandom));
    else send_item(chr_pkg::MODE_RSVD, $urandom, 4'($urandom));
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    idle_cycles = 0;
    no_idle = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty ring cases, extremes, duplicates, misses, unused mode
    send_item(chr_pkg::MODE_LOOKUP, 32'h0, 4'h0);
    send_item(chr_pkg::MODE_DELETE, 32'hFFFF_FFFF, 4'h0);
    send_item(chr_pkg::MODE_INSERT, 32'h8000_0000, 4'hF);
    send_item(chr_pkg::MODE_INSERT, 32'h0, 4'h0);
    send_item(chr_pkg::MODE_INSERT, 32'hFFFF_FFFF, 4'hA);
    send_item(chr_pkg::MODE_INSERT, 32'h8000_0000, 4'h5);
    send_item(chr_pkg::MODE_LOOKUP, 32'h0, 4'h0);
    send_item(chr_pkg::MODE_LOOKUP, 32'h8000_0001, 4'h0);
    send_item(chr_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 4'h0);
    send_item(chr_pkg::MODE_DELETE, 32'h1234_5678, 4'h0);
    send_item(chr_pkg::MODE_RSVD, 32'hFFFF_FFFF, 4'hF);
    send_item(chr_pkg::MODE_DELETE, 32'hFFFF_FFFF, 4'h0);
    send_item(chr_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 4'h0);
    send_item(chr_pkg::MODE_DELETE, 32'h0, 4'h0);
    send_item(chr_pkg::MODE_DELETE, 32'h8000_0000, 4'h0);
    send_item(chr_pkg::MODE_LOOKUP, 32'h5555_5555, 4'h0);

    // Fill to capacity, hit with full and duplicate inserts, then empty it
    no_idle = 1'b1;
    for (i = 0; i < chr_tb_pkg::RING_DEPTH; i++)
      send_item(chr_pkg::MODE_INSERT, 32'(i) * 32'h0100_0001, 4'(i));
    no_idle = 1'b0;
    send_item(chr_pkg::MODE_INSERT, 32'hDEAD_BEEF, 4'h3);
    send_item(chr_pkg::MODE_INSERT, 32'h0100_0001, 4'h3);
    send_item(chr_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 4'h0);
    for (i = 0; i < chr_tb_pkg::RING_DEPTH; i++)
      send_item(chr_pkg::MODE_DELETE, 32'(i) * 32'h0100_0001, 4'h0);

    // Random inserts, lookups, deletes, unused modes on a churning ring
    for (i = 0; i < 420; i++) random_item();
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d lookups and %0d full-ring inserts plus random churn",
             lookups_seen, full_seen);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
